// File: src/complex_signal_energy_dc_removed_defines.svh
// Assertion macros shared by the mean energy block.
`ifndef COMPLEX_SIGNAL_ENERGY_DC_REMOVED_DEFINES_SVH
`define COMPLEX_SIGNAL_ENERGY_DC_REMOVED_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSEDR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSEDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/csedr_pkg.sv
// Types and constants shared by the mean energy block.
package csedr_pkg;

  localparam int MAX_LENGTH   = 4096;
  localparam int COUNT_W      = $clog2(MAX_LENGTH + 1);
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = 32;
  localparam int ENERGY_W     = 31;
  localparam int ENERGY_SHIFT = 4;
  localparam int DIV_W        = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_W);
  localparam int APB_ADDR_W   = 2;
  localparam int APB_DATA_W   = 32;

  localparam logic [APB_ADDR_W-1:0] REG_REMOVE_DC   = 2'd0;
  localparam logic                  REMOVE_DC_RESET = 1'b1;

  typedef enum logic [2:0] {
    ST_SAMPLE,
    ST_DRAIN,
    ST_DIV_E_START,
    ST_DIV_E_WAIT,
    ST_DIV_D_START,
    ST_DIV_D_WAIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic start_e;
    logic capture_e;
    logic start_d;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: src/csedr_div.sv
// Restoring divider that produces one quotient bit per cycle.
module csedr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [csedr_pkg::DIV_W-1:0]   dividend,
  input  logic [csedr_pkg::DIV_W-1:0]   divisor,
  output logic [csedr_pkg::DIV_W-1:0]   quotient,
  output logic                          done
);
  import csedr_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W-1:0]     rem_next;
  logic [DIV_W-1:0]     quo_next;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       trial;

  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    trial   = shifted - {1'b0, dvs};
    if (!trial[DIV_W]) begin
      rem_next = trial[DIV_W-1:0];
      quo_next = {quo[DIV_W-2:0], 1'b1};
    end else begin
      rem_next = shifted[DIV_W-1:0];
      quo_next = {quo[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// File: src/csedr_datapath.sv
// Accumulators, configuration register, divider and output register.
module csedr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  csedr_pkg::cmd_t                       cmd,
  output csedr_pkg::status_t                    status,
  input  logic signed [csedr_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [csedr_pkg::SAMPLE_W-1:0] sample_im,
  input  logic                                  last,
  output logic [csedr_pkg::ENERGY_W-1:0]        energy,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [csedr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [csedr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [csedr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready
);
  import csedr_pkg::*;

  logic                       remove_dc;
  logic [COUNT_W-1:0]         count;
  logic [COUNT_W-1:0]         count_inc;
  logic [SAMPLE_W-1:0]        real_sum;
  logic [SAMPLE_W-1:0]        imag_sum;
  logic [SUM_W-1:0]           energy_sum;
  logic signed [SUM_W-1:0]    sq_re;
  logic signed [SUM_W-1:0]    sq_im;
  logic signed [SUM_W-1:0]    prod_re;
  logic signed [SUM_W-1:0]    prod_im;
  logic [SUM_W-1:0]           sq_sum;
  logic                       acc_pend;
  logic                       counting;
  logic                       acc;
  logic signed [SUM_W-1:0]    dc_re;
  logic signed [SUM_W-1:0]    dc_im;
  logic [SUM_W-1:0]           dc_power;
  logic [SUM_W-1:0]           count_sq;
  logic [2*COUNT_W-1:0]       count_sq_full;
  logic [DIV_W-1:0]           div_dividend;
  logic [DIV_W-1:0]           div_divisor;
  logic [DIV_W-1:0]           quotient;
  logic                       div_done;
  logic [SUM_W-1:0]           e_quo;
  logic [SUM_W-1:0]           e_val;
  logic [SUM_W-1:0]           diff;
  logic [SUM_W-1:0]           result;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_REMOVE_DC) ? APB_DATA_W'(remove_dc) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      remove_dc <= REMOVE_DC_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_REMOVE_DC) begin
      remove_dc <= pwdata[0];
    end
  end

  assign counting  = (count != COUNT_W'(MAX_LENGTH));
  assign count_inc = count + 1'b1;
  assign acc       = counting && !(last && count_inc[0]);
  assign prod_re   = SUM_W'(sample_re) * SUM_W'(sample_re);
  assign prod_im   = SUM_W'(sample_im) * SUM_W'(sample_im);
  assign sq_sum    = sq_re + sq_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      real_sum   <= '0;
      imag_sum   <= '0;
      energy_sum <= '0;
      acc_pend   <= 1'b0;
    end else if (cmd.load_result) begin
      count      <= '0;
      real_sum   <= '0;
      imag_sum   <= '0;
      energy_sum <= '0;
      acc_pend   <= 1'b0;
    end else begin
      acc_pend <= cmd.take && acc;
      if (acc_pend) begin
        energy_sum <= energy_sum
                    + {{ENERGY_SHIFT{sq_sum[SUM_W-1]}}, sq_sum[SUM_W-1:ENERGY_SHIFT]};
      end
      if (cmd.take && counting) begin
        count <= count_inc;
      end
      if (cmd.take && acc) begin
        real_sum <= real_sum + sample_re;
        imag_sum <= imag_sum + sample_im;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sq_re <= prod_re;
      sq_im <= prod_im;
    end
  end

  assign count_sq_full = (2*COUNT_W)'(count) * (2*COUNT_W)'(count);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dc_re    <= SUM_W'($signed(real_sum)) * SUM_W'($signed(real_sum));
      dc_im    <= SUM_W'($signed(imag_sum)) * SUM_W'($signed(imag_sum));
      count_sq <= SUM_W'(count_sq_full);
    end
    if (cmd.start_e) begin
      dc_power <= dc_re + dc_im;
    end
    if (cmd.capture_e) begin
      e_quo <= quotient;
    end
  end

  assign div_dividend = cmd.start_d ? dc_power : energy_sum;
  assign div_divisor  = cmd.start_d ? count_sq : DIV_W'(count);

  csedr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_e || cmd.start_d),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    e_val = e_quo << ENERGY_SHIFT;
    diff  = remove_dc ? (e_val - quotient) : e_val;
    if (diff == '0 || diff[SUM_W-1]) begin
      result = SUM_W'(1);
    end else begin
      result = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      energy <= result[ENERGY_W-1:0];
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

// File: src/csedr_ctrl.sv
// Controller that sequences sample intake, the two divisions and the result.
`include "complex_signal_energy_dc_removed_defines.svh"

module csedr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                last,
  output logic                in_ready,
  input  csedr_pkg::status_t  status,
  output csedr_pkg::cmd_t     cmd
);
  import csedr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SAMPLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_SAMPLE: begin
        if (in_valid && last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DIV_E_START;
      end
      ST_DIV_E_START: begin
        state_next = ST_DIV_E_WAIT;
      end
      ST_DIV_E_WAIT: begin
        if (status.div_done) begin
          state_next = ST_DIV_D_START;
        end
      end
      ST_DIV_D_START: begin
        state_next = ST_DIV_D_WAIT;
      end
      ST_DIV_D_WAIT: begin
        if (status.div_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_next = ST_SAMPLE;
        end
      end
      default: begin
        state_next = ST_SAMPLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_SAMPLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_DRAIN: begin
        cmd.prep = 1'b1;
      end
      ST_DIV_E_START: begin
        cmd.start_e = 1'b1;
      end
      ST_DIV_E_WAIT: begin
        cmd.capture_e = status.div_done;
      end
      ST_DIV_D_START: begin
        cmd.start_d = 1'b1;
      end
      ST_DIV_D_WAIT: begin
        cmd = '0;
      end
      ST_RESULT: begin
        cmd.load_result = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `CSEDR_ASSERT_SAME(a_done_in_wait, status.div_done,
    state == ST_DIV_E_WAIT || state == ST_DIV_D_WAIT, "divider finished outside a wait state")
  `CSEDR_ASSERT_NEXT(a_closing_stops_intake, in_valid && in_ready && last,
    !in_ready, "intake continued after a closing sample")
  `CSEDR_ASSERT_NEXT(a_result_reopens, cmd.load_result,
    in_ready, "intake not reopened after the result was loaded")

endmodule

// File: src/complex_signal_energy_dc_removed.sv
// Top level of the mean energy block with optional DC power removal.
//
// Samples enter on the input channel (in_valid, in_ready) as sample_re,
// sample_im and last. Within a block one sample is taken in every cycle
// that in_valid is high. The transfer that carries last closes the block;
// intake then stops while the energy sum is divided by the sample count
// and the DC power is divided by the squared count; remove_dc selects
// whether that second quotient is subtracted. One shared divider makes one
// quotient bit per cycle for both divisions; once both are done, energy is
// loaded into the output register and in_ready rises again. The output
// channel (out_valid, out_ready) holds the result until its transfer
// completes; a stalled receiver delays the loading of the next block's
// result, and intake stays closed until the waiting result has been taken.
// Synchronous reset clears the sums, the count and any pending result, and
// sets remove_dc to 1. The remove_dc register sits at APB byte address 0
// and the user must write it only while the block is idle (not enforced).
module complex_signal_energy_dc_removed (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [csedr_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [csedr_pkg::SAMPLE_W-1:0] sample_im,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [csedr_pkg::ENERGY_W-1:0]        energy,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [csedr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [csedr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [csedr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready
);
  import csedr_pkg::*;

  cmd_t    cmd;
  status_t status;

  csedr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  csedr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample_re (sample_re),
    .sample_im (sample_im),
    .last      (last),
    .energy    (energy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

endmodule
